### rtl/assert_macros.svh
// Assertion helpers used by sample_voice_envelope_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SVE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/sve_pkg.sv
package sve_pkg;

    localparam int LEVEL_W = 8;
    localparam int PROD_W  = 2 * LEVEL_W;
    localparam logic [LEVEL_W-1:0] PEAK_LEVEL = 8'hFF;

    // Command codes carried on the input word
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_START   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_KILL    = 2'd3
    } cmd_t;

    // Envelope phase before release / echo take over
    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2
    } env_phase_t;

    // Reported phase code
    typedef enum logic [2:0] {
        PC_ATTACK  = 3'd0,
        PC_DECAY   = 3'd1,
        PC_SUSTAIN = 3'd2,
        PC_RELEASE = 3'd3,
        PC_ECHO    = 3'd4,
        PC_OFF     = 3'd5
    } phase_code_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ATTACK_RATE   = 3'd0,
        REG_DECAY_RATE    = 3'd1,
        REG_SUSTAIN_LEVEL = 3'd2,
        REG_RELEASE_RATE  = 3'd3,
        REG_ECHO_LEVEL    = 3'd4,
        REG_ECHO_TICKS    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_rate;
        logic [LEVEL_W-1:0] decay_rate;
        logic [LEVEL_W-1:0] sustain_level;
        logic [LEVEL_W-1:0] release_rate;
        logic [LEVEL_W-1:0] echo_level;
        logic [LEVEL_W-1:0] echo_ticks;
    } cfg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ENV_MUL,
        ST_VOL_MUL,
        ST_LR_MUL,
        ST_DONE
    } state_t;

endpackage

### rtl/sve_serial_mul.sv
// Bit-serial 8x8 unsigned multiplier: one multiplier bit per cycle, LSB first.
module sve_serial_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sve_pkg::LEVEL_W-1:0]   mcand,
    input  logic [sve_pkg::LEVEL_W-1:0]   mplier,
    output logic                          done,
    output logic [sve_pkg::PROD_W-1:0]    prod
);
    import sve_pkg::*;

    localparam int CNT_W = $clog2(LEVEL_W);

    logic                 run_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [LEVEL_W-1:0]   mcand_reg;
    logic [LEVEL_W-1:0]   mplier_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [LEVEL_W:0]     psum;

    // partial sum of the upper half and the current multiplicand term
    assign psum = {1'b0, prod_reg[PROD_W-1:LEVEL_W]}
                + (mplier_reg[0] ? {1'b0, mcand_reg} : '0);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(LEVEL_W - 1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // shift-add datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            prod_reg   <= '0;
        end
        else if (run_reg)
        begin
            mplier_reg <= {1'b0, mplier_reg[LEVEL_W-1:1]};
            prod_reg   <= {psum, prod_reg[LEVEL_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

### rtl/sve_cfg_regs.sv
// Configuration register file; writes beyond the register list are dropped.
module sve_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [2:0]                  wr_index,
    input  logic [sve_pkg::LEVEL_W-1:0] wr_data,
    output sve_pkg::cfg_t               cfg
);
    import sve_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_ATTACK_RATE:   cfg_next.attack_rate   = wr_data;
                REG_DECAY_RATE:    cfg_next.decay_rate    = wr_data;
                REG_SUSTAIN_LEVEL: cfg_next.sustain_level = wr_data;
                REG_RELEASE_RATE:  cfg_next.release_rate  = wr_data;
                REG_ECHO_LEVEL:    cfg_next.echo_level    = wr_data;
                REG_ECHO_TICKS:    cfg_next.echo_ticks    = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_rate   <= PEAK_LEVEL;
            cfg_reg.decay_rate    <= '0;
            cfg_reg.sustain_level <= PEAK_LEVEL;
            cfg_reg.release_rate  <= '0;
            cfg_reg.echo_level    <= '0;
            cfg_reg.echo_ticks    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/sample_voice_envelope_core.sv
// Envelope generator for one sample voice (attack, decay, sustain, release,
// echo tail), and left/right volume scaling on ticks leaving the voice on.
// Input channel: in_valid / in_stall with cmd (tick, start, release, kill),
//   master_volume, right_volume, left_volume. One input word gives exactly
//   one output word on out_valid / out_stall carrying envelope_level,
//   right_level, left_level, voice_on and phase_code.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always
//   ready, write only while no word is in flight.
// Sequence: a word runs ST_EXEC, any multiply steps, then ST_DONE, which
//   writes the output register once it is free. Start, release, kill and
//   a tick on an idle voice need no multiply. Each product goes through a
//   bit-serial 8x8 multiplier (envelope on a tick with decay or release,
//   master volume, then left and right in parallel on two units). One
//   word is in work at a time; the next is accepted the cycle after its
//   result is written to the output register.
// Stall: a result waits in the output register; a later word may be accepted
//   meanwhile, but its result is held back until the register frees up.
// Reset: voice off, out_valid low, level and right/left zero, config reset.
`include "assert_macros.svh"

module sample_voice_envelope_core (
    input  logic       clk,
    input  logic       rst_n,
    // config write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    // input words
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [3:0] master_volume,
    input  logic [7:0] right_volume,
    input  logic [7:0] left_volume,
    // output words
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] envelope_level,
    output logic [7:0] right_level,
    output logic [7:0] left_level,
    output logic       voice_on,
    output logic [2:0] phase_code
);
    import sve_pkg::*;

    cfg_t cfg;

    state_t state_reg, state_next;

    // accepted word
    cmd_t               cmd_reg;
    logic [3:0]         master_reg;
    logic [LEVEL_W-1:0] rvol_reg;
    logic [LEVEL_W-1:0] lvol_reg;

    // voice state
    logic               active_reg,  active_next;
    env_phase_t         phase_reg,   phase_next;
    logic               release_reg, release_next;
    logic               echo_reg,    echo_next;
    logic [LEVEL_W-1:0] level_reg,   level_next;
    logic [LEVEL_W-1:0] ecnt_reg,    ecnt_next;
    logic [LEVEL_W-1:0] right_reg,   right_next;
    logic [LEVEL_W-1:0] left_reg,    left_next;
    logic [LEVEL_W-1:0] vol_reg,     vol_next;

    // output register
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic [LEVEL_W-1:0] out_right_reg;
    logic [LEVEL_W-1:0] out_left_reg;
    logic               out_on_reg;
    phase_code_t        out_code_reg;
    phase_code_t        code_now;

    logic               out_free;
    logic               go_env;
    logic               go_vol;
    logic [LEVEL_W:0]   attack_sum;
    logic [LEVEL_W-1:0] ecnt_dec;
    logic [LEVEL_W-1:0] env_prod;

    // multipliers
    logic               mul_start_a, mul_start_b;
    logic [LEVEL_W-1:0] mul_mcand_a, mul_mplier_a;
    logic               mul_done_a,  mul_done_b;
    logic [PROD_W-1:0]  mul_prod_a,  mul_prod_b;

    sve_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sve_serial_mul u_mul_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_a),
        .mcand  (mul_mcand_a),
        .mplier (mul_mplier_a),
        .done   (mul_done_a),
        .prod   (mul_prod_a)
    );

    // left channel unit, runs alongside the right channel
    sve_serial_mul u_mul_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_b),
        .mcand  (vol_next),
        .mplier (lvol_reg),
        .done   (mul_done_b),
        .prod   (mul_prod_b)
    );

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign attack_sum = {1'b0, level_reg} + {1'b0, cfg.attack_rate};
    assign ecnt_dec   = ecnt_reg - 1'b1;
    assign env_prod   = mul_prod_a[PROD_W-1:LEVEL_W];

    // voice state update
    always_comb
    begin
        active_next  = active_reg;
        phase_next   = phase_reg;
        release_next = release_reg;
        echo_next    = echo_reg;
        level_next   = level_reg;
        ecnt_next    = ecnt_reg;
        right_next   = right_reg;
        left_next    = left_reg;
        vol_next     = vol_reg;
        go_env       = 1'b0;
        go_vol       = 1'b0;
        case (state_reg)
            ST_EXEC:
            begin
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (active_reg)
                        begin
                            if (echo_reg)
                            begin
                                // countdown ends at zero or negative
                                ecnt_next = ecnt_dec;
                                if (ecnt_dec == '0 || ecnt_dec[LEVEL_W-1])
                                    active_next = 1'b0;
                                else
                                    go_vol = 1'b1;
                            end
                            else if (release_reg || phase_reg == PH_DECAY)
                            begin
                                go_env = 1'b1;
                            end
                            else if (phase_reg == PH_ATTACK)
                            begin
                                if (attack_sum >= {1'b0, PEAK_LEVEL})
                                begin
                                    level_next = PEAK_LEVEL;
                                    phase_next = PH_DECAY;
                                end
                                else
                                begin
                                    level_next = attack_sum[LEVEL_W-1:0];
                                end
                                go_vol = 1'b1;
                            end
                            else
                            begin
                                go_vol = 1'b1;
                            end
                        end
                    end
                    CMD_START:
                    begin
                        active_next  = 1'b1;
                        release_next = 1'b0;
                        echo_next    = 1'b0;
                        ecnt_next    = cfg.echo_ticks;
                        if (cfg.attack_rate == PEAK_LEVEL)
                        begin
                            level_next = PEAK_LEVEL;
                            phase_next = PH_DECAY;
                        end
                        else
                        begin
                            level_next = cfg.attack_rate;
                            phase_next = PH_ATTACK;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (active_reg)
                            release_next = 1'b1;
                    end
                    default:
                    begin
                        active_next = 1'b0;
                    end
                endcase
            end
            ST_ENV_MUL:
            begin
                if (mul_done_a)
                begin
                    if ((release_reg && env_prod <= cfg.echo_level)
                        || (!release_reg && env_prod <= cfg.sustain_level
                            && cfg.sustain_level == '0))
                    begin
                        // enter the echo tail, or end the note without one
                        if (cfg.echo_level == '0)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            level_next = cfg.echo_level;
                            echo_next  = 1'b1;
                            go_vol     = 1'b1;
                        end
                    end
                    else if (!release_reg && env_prod <= cfg.sustain_level)
                    begin
                        level_next = cfg.sustain_level;
                        phase_next = PH_SUSTAIN;
                        go_vol     = 1'b1;
                    end
                    else
                    begin
                        level_next = env_prod;
                        go_vol     = 1'b1;
                    end
                end
            end
            ST_VOL_MUL:
            begin
                if (mul_done_a)
                    vol_next = mul_prod_a[LEVEL_W+3:4];
            end
            ST_LR_MUL:
            begin
                if (mul_done_a)
                begin
                    right_next = mul_prod_a[PROD_W-1:LEVEL_W];
                    left_next  = mul_prod_b[PROD_W-1:LEVEL_W];
                end
            end
            default:
            begin
                go_env = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (go_env)
                    state_next = ST_ENV_MUL;
                else if (go_vol)
                    state_next = ST_VOL_MUL;
                else
                    state_next = ST_DONE;
            end
            ST_ENV_MUL:
            begin
                if (mul_done_a)
                    state_next = go_vol ? ST_VOL_MUL : ST_DONE;
            end
            ST_VOL_MUL:
            begin
                if (mul_done_a)
                    state_next = ST_LR_MUL;
            end
            ST_LR_MUL:
            begin
                if (mul_done_a)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // multiplier launch and operand select
    always_comb
    begin
        mul_start_a  = 1'b0;
        mul_start_b  = 1'b0;
        mul_mcand_a  = level_next;
        mul_mplier_a = {4'b0000, master_reg} + 8'd1;
        case (state_reg)
            ST_EXEC:
            begin
                if (go_env)
                begin
                    mul_start_a  = 1'b1;
                    mul_mcand_a  = level_reg;
                    mul_mplier_a = release_reg ? cfg.release_rate : cfg.decay_rate;
                end
                else if (go_vol)
                begin
                    mul_start_a = 1'b1;
                end
            end
            ST_ENV_MUL:
            begin
                mul_start_a = go_vol;
            end
            ST_VOL_MUL:
            begin
                if (mul_done_a)
                begin
                    mul_start_a  = 1'b1;
                    mul_start_b  = 1'b1;
                    mul_mcand_a  = vol_next;
                    mul_mplier_a = rvol_reg;
                end
            end
            default:
            begin
                mul_start_a = 1'b0;
            end
        endcase
    end

    // phase code from the updated state
    always_comb
    begin
        if (!active_reg)
            code_now = PC_OFF;
        else if (echo_reg)
            code_now = PC_ECHO;
        else if (release_reg)
            code_now = PC_RELEASE;
        else
        begin
            case (phase_reg)
                PH_ATTACK: code_now = PC_ATTACK;
                PH_DECAY:  code_now = PC_DECAY;
                default:   code_now = PC_SUSTAIN;
            endcase
        end
    end

    // control and voice state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            phase_reg     <= PH_ATTACK;
            release_reg   <= 1'b0;
            echo_reg      <= 1'b0;
            level_reg     <= '0;
            ecnt_reg      <= '0;
            right_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            phase_reg   <= phase_next;
            release_reg <= release_next;
            echo_reg    <= echo_next;
            level_reg   <= level_next;
            ecnt_reg    <= ecnt_next;
            right_reg   <= right_next;
            left_reg    <= left_next;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        vol_reg <= vol_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            cmd_reg    <= cmd_t'(cmd);
            master_reg <= master_volume;
            rvol_reg   <= right_volume;
            lvol_reg   <= left_volume;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_level_reg <= level_reg;
            out_right_reg <= right_reg;
            out_left_reg  <= left_reg;
            out_on_reg    <= active_reg;
            out_code_reg  <= code_now;
        end
    end

    assign out_valid      = out_valid_reg;
    assign envelope_level = out_level_reg;
    assign right_level    = out_right_reg;
    assign left_level     = out_left_reg;
    assign voice_on       = out_on_reg;
    assign phase_code     = out_code_reg;

    // checks
    `SVE_ASSERT_NOW(a_mul_done_in_mul_state, clk, rst_n, mul_done_a,
        (state_reg == ST_ENV_MUL || state_reg == ST_VOL_MUL || state_reg == ST_LR_MUL))
    `SVE_ASSERT_NOW(a_lr_units_in_step, clk, rst_n,
        (state_reg == ST_LR_MUL && mul_done_a), mul_done_b)
    `SVE_ASSERT_NEXT(a_accept_goes_exec, clk, rst_n, (in_valid && !in_stall),
        (state_reg == ST_EXEC))
    `SVE_ASSERT_NEXT(a_done_posts_result, clk, rst_n, (state_reg == ST_DONE && out_free),
        (out_valid_reg && state_reg == ST_IDLE))

endmodule
